@@ hw/rtl/scgtm_pkg.sv @@
package scgtm_pkg;

    // gas window geometry
    localparam int WINDOW   = 4;
    localparam int SLOT_W   = $clog2(WINDOW);
    localparam int GAS_W    = 15;
    localparam int SUM_W    = GAS_W + $clog2(WINDOW);
    localparam int TRIM_DIV = WINDOW - 2;

    // ppm conversion: divide by 33 as multiply by ceil(2^20 / 33), exact below 2^15
    localparam int PPM_W     = 10;
    localparam int PROD_W    = 2 * GAS_W;
    localparam int PPM_SHIFT = 20;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 32;

    typedef logic [GAS_W-1:0]  gas_t;
    typedef logic [PPM_W-1:0]  ppm_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef gas_t window_t [WINDOW];

    localparam gas_t GAS_CLAMP = 15'd32767;
    localparam gas_t PPM_RECIP = 15'd31776;
    localparam ppm_t PPM_CAP   = 10'd1000;

    // register reset values
    localparam logic signed [CFG_W-1:0] TEMP_MIN_RST  = -16'sd400;
    localparam logic signed [CFG_W-1:0] TEMP_MAX_RST  = 16'sd850;
    localparam logic signed [CFG_W-1:0] HUMID_MIN_RST = 16'sd0;
    localparam logic signed [CFG_W-1:0] HUMID_MAX_RST = 16'sd1000;
    localparam logic [CFG_W-1:0]        DUST_MAX_RST  = 16'd500;
    localparam logic [CFG_W-1:0]        RAW_LIMIT_RST = 16'd60000;
    localparam gas_t                    GAS_ZERO_RST  = 15'd150;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_MIN  = 3'd0,
        REG_TEMP_MAX  = 3'd1,
        REG_HUMID_MIN = 3'd2,
        REG_HUMID_MAX = 3'd3,
        REG_DUST_MAX  = 3'd4,
        REG_RAW_LIMIT = 3'd5,
        REG_GAS_ZERO  = 3'd6
    } cfg_reg_t;

    // error flags carried along the pipeline
    typedef struct packed {
        logic climate;
        logic dust;
        logic gas;
    } err_flags_t;

endpackage

@@ hw/rtl/scgtm_trim_mean.sv @@
module scgtm_trim_mean (
    input  scgtm_pkg::window_t win,
    output scgtm_pkg::gas_t    filt
);
    import scgtm_pkg::*;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] trim;
    gas_t             mx;
    gas_t             mn;

    // largest, smallest and total of the window
    always_comb begin
        sum = '0;
        mx  = '0;
        mn  = '1;
        for (int i = 0; i < WINDOW; i++) begin
            if (win[i] > mx) begin
                mx = win[i];
            end
            if (win[i] < mn) begin
                mn = win[i];
            end
            sum = sum + SUM_W'(win[i]);
        end
    end

    // drop one largest and one smallest, mean of the rest
    always_comb begin
        trim = sum - SUM_W'(mx) - SUM_W'(mn);
        filt = GAS_W'(trim / TRIM_DIV);
    end

endmodule

@@ hw/rtl/scgtm_ppm.sv @@
module scgtm_ppm (
    input  scgtm_pkg::gas_t filt,
    input  scgtm_pkg::gas_t gas_zero,
    output scgtm_pkg::ppm_t ppm
);
    import scgtm_pkg::*;

    gas_t              diff;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;

    // (filt - gas_zero) / 33 by reciprocal multiply
    always_comb begin
        diff = filt - gas_zero;
        prod = PROD_W'(diff) * PROD_W'(PPM_RECIP);
        quot = prod >> PPM_SHIFT;
        if (filt <= gas_zero) begin
            ppm = '0;
        end else if (quot > PROD_W'(PPM_CAP)) begin
            ppm = PPM_CAP;
        end else begin
            ppm = PPM_W'(quot);
        end
    end

endmodule

@@ hw/rtl/sensor_check_and_gas_trimmed_mean_top.sv @@
// Sensor sample checker with a trimmed-mean gas filter.
//
// Input stream (s_*): one transfer carries one sample set: temperature,
// humidity, dust level, raw dust and raw gas readings. Output stream (m_*):
// one transfer per input with the climate, dust and gas error flags, the
// filtered gas level and the gas ppm value.
// An input transfer reaches m_tvalid via the stage 1, stage 2 and output
// registers. One sample set per cycle unless m_tready stalls; three stages:
// ring update and flags, trimmed mean, reciprocal multiply for ppm.
// The gas ring is written on the input transfer, so filtering follows the
// order of accepted samples regardless of stalls.
// Configuration registers are written through cfg_wr_en / cfg_index /
// cfg_wdata by the user only while the stream is idle; the block does not
// enforce it; unknown indexes are ignored. Reset (aresetn low, synchronous)
// empties the pipeline, clears the gas ring and write slot to zero and
// loads the default limits. When the receiver holds m_tready low the result
// is kept in the output register; stages behind it keep filling and s_tready
// drops only when all three stages are full.
module sensor_check_and_gas_trimmed_mean_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // temperature[15:0], humidity[31:16], dust_level[47:32],
    // dust_raw[63:48], gas_sample[79:64]
    input  logic [scgtm_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // climate_error[0], dust_error[1], gas_error[2], gas_filtered[17:3],
    // gas_ppm[27:18], zero[31:28]
    output logic [scgtm_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_wr_en,
    input  logic [scgtm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scgtm_pkg::CFG_W-1:0]          cfg_wdata
);
    import scgtm_pkg::*;

    // configuration registers
    logic signed [CFG_W-1:0] temp_min_reg;
    logic signed [CFG_W-1:0] temp_max_reg;
    logic signed [CFG_W-1:0] humid_min_reg;
    logic signed [CFG_W-1:0] humid_max_reg;
    logic [CFG_W-1:0]        dust_max_reg;
    logic [CFG_W-1:0]        raw_limit_reg;
    gas_t                    gas_zero_reg;

    // input fields
    logic signed [SAMPLE_W-1:0] temperature;
    logic signed [SAMPLE_W-1:0] humidity;
    logic [SAMPLE_W-1:0]        dust_level;
    logic [SAMPLE_W-1:0]        dust_raw;
    logic [SAMPLE_W-1:0]        gas_sample;

    // ring state
    window_t ring_reg;
    window_t ring_next;
    slot_t   slot_reg;
    slot_t   slot_next;
    gas_t    gas_clamped;

    // pipeline
    logic       s_xfer;
    logic       rdy1;
    logic       rdy2;
    logic       rdy3;
    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    window_t    win1_reg;
    err_flags_t err1_reg;
    err_flags_t err_next;
    gas_t       filt1;
    gas_t       filt2_reg;
    err_flags_t err2_reg;
    ppm_t       ppm2;
    logic [M_DATA_W-1:0] data3_reg;

    assign temperature = s_tdata[15:0];
    assign humidity    = s_tdata[31:16];
    assign dust_level  = s_tdata[47:32];
    assign dust_raw    = s_tdata[63:48];
    assign gas_sample  = s_tdata[79:64];

    // stage enables, each stage moves when the one after it has room
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign s_xfer   = s_tvalid && s_tready;

    // configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_min_reg  <= TEMP_MIN_RST;
            temp_max_reg  <= TEMP_MAX_RST;
            humid_min_reg <= HUMID_MIN_RST;
            humid_max_reg <= HUMID_MAX_RST;
            dust_max_reg  <= DUST_MAX_RST;
            raw_limit_reg <= RAW_LIMIT_RST;
            gas_zero_reg  <= GAS_ZERO_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TEMP_MIN:  temp_min_reg  <= cfg_wdata;
                REG_TEMP_MAX:  temp_max_reg  <= cfg_wdata;
                REG_HUMID_MIN: humid_min_reg <= cfg_wdata;
                REG_HUMID_MAX: humid_max_reg <= cfg_wdata;
                REG_DUST_MAX:  dust_max_reg  <= cfg_wdata;
                REG_RAW_LIMIT: raw_limit_reg <= cfg_wdata;
                REG_GAS_ZERO:  gas_zero_reg  <= cfg_wdata[GAS_W-1:0];
                default: ;
            endcase
        end
    end

    // range checks on the incoming sample set
    always_comb begin
        err_next.climate = (temperature < temp_min_reg) || (temperature > temp_max_reg) ||
                           (humidity < humid_min_reg) || (humidity > humid_max_reg);
        err_next.dust    = (dust_raw == '0) || (dust_raw > raw_limit_reg) ||
                           (dust_level > dust_max_reg);
        err_next.gas     = (gas_sample == '0) || (gas_sample > raw_limit_reg);
    end

    // clamp and ring write
    always_comb begin
        gas_clamped = (gas_sample > SAMPLE_W'(GAS_CLAMP)) ? GAS_CLAMP
                                                          : gas_sample[GAS_W-1:0];
        ring_next = ring_reg;
        ring_next[slot_reg] = gas_clamped;
        slot_next = (slot_reg == slot_t'(WINDOW - 1)) ? '0 : slot_reg + slot_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg <= '0;
        end else if (s_xfer) begin
            ring_reg <= ring_next;
            slot_reg <= slot_next;
        end
    end

    // stage 1: window snapshot and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            win1_reg <= ring_next;
            err1_reg <= err_next;
        end
    end

    scgtm_trim_mean u_trim_mean (
        .win  (win1_reg),
        .filt (filt1)
    );

    // stage 2: filtered gas level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            filt2_reg <= filt1;
            err2_reg  <= err1_reg;
        end
    end

    scgtm_ppm u_ppm (
        .filt     (filt2_reg),
        .gas_zero (gas_zero_reg),
        .ppm      (ppm2)
    );

    // stage 3: output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            data3_reg <= {4'b0000, ppm2, filt2_reg,
                          err2_reg.gas, err2_reg.dust, err2_reg.climate};
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = data3_reg;

`ifndef SYNTH
    // accepted sample always lands in stage 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> v1_reg)
        else $error("accepted sample not captured in stage 1");

    // write slot advances by one per transfer and wraps
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> (slot_reg == (($past(slot_reg) == slot_t'(WINDOW - 1)) ? slot_t'(0)
                                  : $past(slot_reg) + slot_t'(1))))
        else $error("write slot did not advance");

    // ppm never exceeds the cap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[27:18] <= PPM_CAP))
        else $error("ppm above cap");

    // nonzero ppm only above the zero threshold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[27:18] == '0) || (m_tdata[17:3] > gas_zero_reg)))
        else $error("ppm nonzero at or below zero threshold");

    // a full pipeline with stalled output refuses input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with no room in pipeline");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import scgtm_pkg::*;

    localparam int PIPE_LATENCY   = 3;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 215;
    localparam int GAS_CEIL       = 32767;
    localparam int PPM_STEP       = 33;
    localparam int PPM_TOP        = 1000;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // one sensor sample set, as carried on s_tdata
    typedef struct {
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
        logic [15:0]        dust_level;
        logic [15:0]        dust_raw;
        logic [15:0]        gas_sample;
    } sample_t;

    // one result, laid out as m_tdata[27:0]
    typedef struct packed {
        ppm_t gas_ppm;
        gas_t gas_filtered;
        logic gas_error;
        logic dust_error;
        logic climate_error;
    } verdict_t;

    typedef struct {
        logic signed [15:0] temp_min;
        logic signed [15:0] temp_max;
        logic signed [15:0] humid_min;
        logic signed [15:0] humid_max;
        logic [15:0]        dust_max;
        logic [15:0]        raw_limit;
        logic [14:0]        gas_zero;
    } limits_t;

    // directed row: either a new limit set or a sample, with an optional fixed result
    typedef struct {
        bit       reprogram;
        limits_t  lim;
        sample_t  smp;
        bit       typed;
        verdict_t want;
    } stim_row_t;

    typedef struct {
        bit       typed;
        verdict_t want;
    } fixed_verdict_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_GAPPY,
        RDY_THIRD
    } ready_mode_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic [S_DATA_W-1:0]     s_tdata   = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [M_DATA_W-1:0]     m_tdata;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_TEMP_MIN;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    // predictor state: limits, gas ring and its write slot
    limits_t lim;
    gas_t    gas_ring [WINDOW];
    int      ring_slot;

    verdict_t       pending_verdicts [$];
    fixed_verdict_t fixed_verdicts [$];
    stim_row_t      stim_table [$];
    int             mismatches = 0;
    int             burst_left = 0;
    int unsigned    cycle_cnt  = 0;
    ready_mode_t    ready_mode = RDY_ALWAYS;
    int             stall_left = 0;

    sensor_check_and_gas_trimmed_mean_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic limits_t mk_limits(int tmin, int tmax, int hmin, int hmax,
                                          int dmax, int raw, int gz);
        limits_t l;
        l.temp_min  = 16'(tmin);
        l.temp_max  = 16'(tmax);
        l.humid_min = 16'(hmin);
        l.humid_max = 16'(hmax);
        l.dust_max  = 16'(dmax);
        l.raw_limit = 16'(raw);
        l.gas_zero  = 15'(gz);
        return l;
    endfunction

    function automatic limits_t default_limits();
        return mk_limits(-400, 850, 0, 1000, 500, 60000, 150);
    endfunction

    function automatic sample_t mk_sample(int t, int h, int dl, int dr, int g);
        sample_t s;
        s.temperature = 16'(t);
        s.humidity    = 16'(h);
        s.dust_level  = 16'(dl);
        s.dust_raw    = 16'(dr);
        s.gas_sample  = 16'(g);
        return s;
    endfunction

    function automatic verdict_t mk_verdict(bit c, bit d, bit g, int filt, int ppm);
        verdict_t v;
        v.climate_error = c;
        v.dust_error    = d;
        v.gas_error     = g;
        v.gas_filtered  = gas_t'(filt);
        v.gas_ppm       = ppm_t'(ppm);
        return v;
    endfunction

    // range flags, then clamp into the ring and take the trimmed mean
    function automatic verdict_t trimmed_gas_verdict(sample_t s);
        verdict_t v;
        gas_t     clamped;
        int       total;
        int       top;
        int       bottom;
        int       trimmed;
        int       ppm;
        v.climate_error = (s.temperature < lim.temp_min) || (s.temperature > lim.temp_max)
                       || (s.humidity < lim.humid_min) || (s.humidity > lim.humid_max);
        v.dust_error = (s.dust_raw == 16'd0) || (s.dust_raw > lim.raw_limit)
                    || (s.dust_level > lim.dust_max);
        v.gas_error = (s.gas_sample == 16'd0) || (s.gas_sample > lim.raw_limit);

        // erroneous readings still go into the ring
        clamped = (int'(s.gas_sample) > GAS_CEIL) ? gas_t'(GAS_CEIL) : s.gas_sample[14:0];
        gas_ring[ring_slot] = clamped;
        ring_slot = (ring_slot + 1) % WINDOW;

        // one copy of the largest and of the smallest entry is dropped
        total  = 0;
        top    = 0;
        bottom = GAS_CEIL + 1;
        foreach (gas_ring[i]) begin
            total += int'(gas_ring[i]);
            if (int'(gas_ring[i]) > top) top = int'(gas_ring[i]);
            if (int'(gas_ring[i]) < bottom) bottom = int'(gas_ring[i]);
        end
        trimmed = (total - top - bottom) / (WINDOW - 2);

        ppm = (trimmed > int'(lim.gas_zero)) ? (trimmed - int'(lim.gas_zero)) / PPM_STEP : 0;
        if (ppm > PPM_TOP) ppm = PPM_TOP;

        v.gas_filtered = gas_t'(trimmed);
        v.gas_ppm      = ppm_t'(ppm);
        return v;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result check, register tracking and prediction on each input transfer
    always @(posedge aclk) begin : monitor
        verdict_t       got;
        verdict_t       want;
        sample_t        arrived;
        fixed_verdict_t fv;
        if (!aresetn) begin
            lim = default_limits();
            foreach (gas_ring[i]) gas_ring[i] = '0;
            ring_slot = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata[27:0]);
                if (pending_verdicts.size() == 0) begin
                    $error("result transfer with no result expected");
                    mismatches++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("climate_error", int'(want.climate_error),
                                int'(got.climate_error));
                    check_field("dust_error", int'(want.dust_error), int'(got.dust_error));
                    check_field("gas_error", int'(want.gas_error), int'(got.gas_error));
                    check_field("gas_filtered", int'(want.gas_filtered),
                                int'(got.gas_filtered));
                    check_field("gas_ppm", int'(want.gas_ppm), int'(got.gas_ppm));
                end
            end

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TEMP_MIN:  lim.temp_min  = cfg_wdata;
                    REG_TEMP_MAX:  lim.temp_max  = cfg_wdata;
                    REG_HUMID_MIN: lim.humid_min = cfg_wdata;
                    REG_HUMID_MAX: lim.humid_max = cfg_wdata;
                    REG_DUST_MAX:  lim.dust_max  = cfg_wdata;
                    REG_RAW_LIMIT: lim.raw_limit = cfg_wdata;
                    REG_GAS_ZERO:  lim.gas_zero  = cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                arrived.temperature = s_tdata[15:0];
                arrived.humidity    = s_tdata[31:16];
                arrived.dust_level  = s_tdata[47:32];
                arrived.dust_raw    = s_tdata[63:48];
                arrived.gas_sample  = s_tdata[79:64];
                want = trimmed_gas_verdict(arrived);
                fv = fixed_verdicts.pop_front();
                pending_verdicts.push_back(fv.typed ? fv.want : want);
            end
        end
    end

    // receiver backpressure, switching pattern whenever the low byte of cycle_cnt is zero
    always @(posedge aclk) begin
        if (cycle_cnt[7:0] == 8'd0) ready_mode <= ready_mode_t'(2'($urandom_range(0, 3)));
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RDY_GAPPY: begin
                if (stall_left != 0) begin
                    m_tready   <= 1'b0;
                    stall_left <= stall_left - 1;
                end else begin
                    m_tready   <= 1'b1;
                    stall_left <= $urandom_range(0, 12);
                end
            end
            default: m_tready <= (cycle_cnt % 3 == 0);
        endcase
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sender: bursts of transfers separated by random gaps
    task automatic send_sample(sample_t s, bit typed, verdict_t want);
        int             gap;
        fixed_verdict_t fv;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        fv.typed = typed;
        fv.want  = want;
        fixed_verdicts.push_back(fv);
        s_tdata  <= {s.gas_sample, s.dust_raw, s.dust_level, s.humidity, s.temperature};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the sender until every result is back and the pipeline is empty
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY) @(posedge aclk);
    endtask

    task automatic program_limits(limits_t l);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_TEMP_MIN;
        cfg_wdata <= l.temp_min;
        @(posedge aclk);
        cfg_index <= REG_TEMP_MAX;
        cfg_wdata <= l.temp_max;
        @(posedge aclk);
        cfg_index <= REG_HUMID_MIN;
        cfg_wdata <= l.humid_min;
        @(posedge aclk);
        cfg_index <= REG_HUMID_MAX;
        cfg_wdata <= l.humid_max;
        @(posedge aclk);
        cfg_index <= REG_DUST_MAX;
        cfg_wdata <= l.dust_max;
        @(posedge aclk);
        cfg_index <= REG_RAW_LIMIT;
        cfg_wdata <= l.raw_limit;
        @(posedge aclk);
        // top bit is outside the register and must be dropped
        cfg_index <= REG_GAS_ZERO;
        cfg_wdata <= {1'($urandom_range(0, 1)), l.gas_zero};
        @(posedge aclk);
        // unmapped index must leave everything alone
        cfg_index <= REG_NONE;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic add_row(sample_t s, bit typed = 1'b0, verdict_t want = '0);
        stim_row_t r;
        r.reprogram = 1'b0;
        r.smp       = s;
        r.typed     = typed;
        r.want      = want;
        stim_table.push_back(r);
    endtask

    task automatic add_limits(limits_t l);
        stim_row_t r;
        r.reprogram = 1'b1;
        r.lim       = l;
        r.typed     = 1'b0;
        r.want      = '0;
        stim_table.push_back(r);
    endtask

    function automatic limits_t rand_limits();
        limits_t l;
        l = mk_limits(-int'($urandom_range(0, 600)), $urandom_range(0, 1200),
                      int'($urandom_range(0, 300)) - 100, $urandom_range(500, 1100),
                      $urandom_range(0, 2000), $urandom_range(1000, 65534),
                      $urandom_range(0, 3000));
        if ($urandom_range(0, 3) == 0) l.raw_limit = 16'hFFFF;
        if ($urandom_range(0, 3) == 0) l.gas_zero = '0;
        // now and then an arbitrary bound, possibly inverted
        if ($urandom_range(0, 4) == 0) l.temp_min = 16'($urandom);
        if ($urandom_range(0, 4) == 0) l.humid_max = 16'($urandom);
        return l;
    endfunction

    // mostly in range, with full-range noise and values around both bounds
    function automatic logic [15:0] pick_field(int lo, int hi);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 16'($urandom);
        if (sel == 1) return 16'(lo + int'($urandom_range(0, 4)) - 2);
        if (sel == 2) return 16'(hi + int'($urandom_range(0, 4)) - 2);
        if (lo <= hi) return 16'(lo + int'($urandom_range(0, hi - lo)));
        return 16'($urandom);
    endfunction

    function automatic sample_t rand_sample(limits_t l);
        sample_t s;
        int      sel;
        s.temperature = pick_field(int'(l.temp_min), int'(l.temp_max));
        s.humidity    = pick_field(int'(l.humid_min), int'(l.humid_max));
        s.dust_level  = pick_field(0, int'(l.dust_max));
        s.dust_raw    = pick_field(1, int'(l.raw_limit));
        sel = $urandom_range(0, 9);
        if (sel == 0)
            s.gas_sample = pick_field(int'(l.raw_limit), int'(l.raw_limit));
        else if (sel == 1)
            s.gas_sample = '0;
        else
            s.gas_sample = pick_field(1, 4000);
        return s;
    endfunction

    initial begin : stimulus
        limits_t cur;
        int      phase;

        // defaults after reset; ring starts cleared so early means are small
        add_row(mk_sample(250, 500, 100, 1000, 200), 1'b1, mk_verdict(0, 0, 0, 0, 0));
        add_row(mk_sample(-400, 1000, 500, 0, 0), 1'b1, mk_verdict(0, 1, 1, 0, 0));
        add_row(mk_sample(-401, 0, 0, 60001, 65535), 1'b1, mk_verdict(1, 1, 1, 100, 0));
        add_row(mk_sample(851, 0, 501, 60000, 60000));
        add_row(mk_sample(0, -1, 0, 1, 60001));
        add_row(mk_sample(0, 1001, 0, 1, 1));
        add_row(mk_sample(-32768, 32767, 65535, 65535, 32768));
        add_row(mk_sample(32767, -32768, 0, 1, 32767));
        // equal readings, then one low outlier among duplicates
        repeat (4) add_row(mk_sample(200, 400, 20, 3000, 5000));
        add_row(mk_sample(200, 400, 20, 3000, 100));
        // min above max: every climate value flagged, zero limits flag all raw readings
        add_limits(mk_limits(100, -100, 500, -500, 0, 0, 0));
        add_row(mk_sample(0, 0, 0, 1, 2));
        add_row(mk_sample(100, 500, 0, 0, 0));
        // widest limits
        add_limits(mk_limits(-32768, 32767, -32768, 32767, 65535, 65535, 32767));
        add_row(mk_sample(-32768, -32768, 65535, 65535, 65535));
        add_row(mk_sample(32767, 32767, 0, 1, 1));
        add_row(mk_sample(0, 0, 0, 0, 0));
        // zero threshold with a saturated ring gives the largest ppm, 992, just below the cap
        add_limits(mk_limits(-400, 850, 0, 1000, 500, 60000, 0));
        repeat (4) add_row(mk_sample(200, 400, 20, 3000, 65535));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            if (stim_table[i].reprogram)
                program_limits(stim_table[i].lim);
            else
                send_sample(stim_table[i].smp, stim_table[i].typed, stim_table[i].want);
        end

        // random phases, each under its own limit set
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            cur = (phase == 0) ? default_limits() : rand_limits();
            program_limits(cur);
            repeat (RAND_PER_PHASE) send_sample(rand_sample(cur), 1'b0, '0);
        end

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
